FILE: sv/dpb_pkg.sv
// Shared types, register indexes and reset values for the depth pixel backprojection unit.
package dpb_pkg;

  localparam int unsigned COORD_IN_W = 12;
  localparam int unsigned DEPTH_W    = 16;
  localparam int unsigned COLOR_W    = 8;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CENTER_W   = 16;
  localparam int unsigned FACTOR_W   = 32;
  localparam int unsigned POINT_W    = 32;

  localparam logic [FACTOR_W-1:0] DEPTH_SCALE_RST = 32'd4294967;
  localparam logic [CENTER_W-1:0] CENTER_RST      = 16'd0;
  localparam logic [FACTOR_W-1:0] FOCAL_INV_RST   = 32'd8589934;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEPTH_SCALE = 3'd0,
    REG_CENTER_X    = 3'd1,
    REG_CENTER_Y    = 3'd2,
    REG_FOCAL_INV_X = 3'd3,
    REG_FOCAL_INV_Y = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [COORD_IN_W-1:0] column;
    logic [COORD_IN_W-1:0] row;
    logic [DEPTH_W-1:0]    depth_raw;
    logic [COLOR_W-1:0]    red;
    logic [COLOR_W-1:0]    green;
    logic [COLOR_W-1:0]    blue;
  } in_item_t;

  typedef struct packed {
    logic                      point_valid;
    logic signed [POINT_W-1:0] point_x;
    logic signed [POINT_W-1:0] point_y;
    logic [POINT_W-1:0]        point_z;
    logic [COLOR_W-1:0]        out_red;
    logic [COLOR_W-1:0]        out_green;
    logic [COLOR_W-1:0]        out_blue;
  } out_item_t;

  // Per-stage load enables, one per pipeline stage
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } stage_ld_t;

endpackage

FILE: sv/dpb_range.sv
// Range pipeline: z = round(depth_raw * depth_scale / 2^16), delayed to line up with the lateral path.
module dpb_range (
  input  logic                          clk,
  input  dpb_pkg::stage_ld_t            ld,
  input  logic [dpb_pkg::DEPTH_W-1:0]   depth_raw,
  input  logic [dpb_pkg::FACTOR_W-1:0]  depth_scale,
  output logic [dpb_pkg::POINT_W-1:0]   z_s2,
  output logic [dpb_pkg::POINT_W-1:0]   z_s3
);
  import dpb_pkg::*;

  localparam int unsigned ZP_W = DEPTH_W + FACTOR_W;

  logic [ZP_W-1:0]    zprod_r;
  logic [ZP_W-1:0]    zrnd_nxt;
  logic [POINT_W-1:0] z_r;
  logic [POINT_W-1:0] z3_r;

  // Round half up; the sum never overflows 48 bits
  assign zrnd_nxt = zprod_r + ZP_W'(32'h0000_8000);

  always_ff @(posedge clk) begin
    if (ld.s1) begin
      zprod_r <= ZP_W'(depth_raw) * ZP_W'(depth_scale);
    end
    if (ld.s2) begin
      z_r <= zrnd_nxt[ZP_W-1:16];
    end
    if (ld.s3) begin
      z3_r <= z_r;
    end
  end

  assign z_s2 = z_r;
  assign z_s3 = z3_r;

endmodule

FILE: sv/dpb_lateral.sv
// Lateral pipeline for one axis: (pix*16 - center) * focal_inverse * z, rounded and saturated.
module dpb_lateral #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                                clk,
  input  dpb_pkg::stage_ld_t                  ld,
  input  logic [dpb_pkg::COORD_IN_W-1:0]      pix,
  input  logic [dpb_pkg::CENTER_W-1:0]        center,
  input  logic [dpb_pkg::FACTOR_W-1:0]        finv,
  input  logic [dpb_pkg::POINT_W-1:0]         z,
  output logic signed [dpb_pkg::POINT_W-1:0]  coord
);
  import dpb_pkg::*;

  localparam int unsigned P4_W   = COORD_BITS + 4;
  localparam int unsigned DMAG_W = (P4_W > CENTER_W) ? P4_W : CENTER_W;
  localparam int unsigned A_W    = DMAG_W + FACTOR_W;
  localparam int unsigned AHI_W  = A_W - 32;
  localparam int unsigned PHI_W  = AHI_W + POINT_W;
  localparam int unsigned PROD_W = A_W + POINT_W;
  localparam int unsigned MAG_W  = PROD_W - 36;

  logic [15:0]         pix16;
  logic [P4_W-1:0]     p4;
  logic [DMAG_W-1:0]   p4_ext;
  logic [DMAG_W-1:0]   c_ext;
  logic                neg_nxt;
  logic [DMAG_W-1:0]   dmag_nxt;

  logic [DMAG_W-1:0]   dmag_r;
  logic                neg1_r;
  logic [A_W-1:0]      a_r;
  logic                neg2_r;
  logic [63:0]         plo_r;
  logic [PHI_W-1:0]    phi_r;
  logic                neg3_r;

  logic [PROD_W-1:0]   prod;
  logic [PROD_W-1:0]   rnd;
  logic [MAG_W-1:0]    mag;
  logic                mag_big;

  // Mask the pixel coordinate and form the signed Q.4 offset as sign and magnitude
  assign pix16    = {{(16 - COORD_IN_W){1'b0}}, pix};
  assign p4       = {pix16[COORD_BITS-1:0], 4'b0000};
  assign p4_ext   = DMAG_W'(p4);
  assign c_ext    = DMAG_W'(center);
  assign neg_nxt  = p4_ext < c_ext;
  assign dmag_nxt = neg_nxt ? (c_ext - p4_ext) : (p4_ext - c_ext);

  always_ff @(posedge clk) begin
    if (ld.s1) begin
      dmag_r <= dmag_nxt;
      neg1_r <= neg_nxt;
    end
    // Scale offset by the inverse focal length
    if (ld.s2) begin
      a_r    <= A_W'(dmag_r) * A_W'(finv);
      neg2_r <= neg1_r;
    end
    // Split the wide factor into two partial products with z
    if (ld.s3) begin
      plo_r  <= 64'(a_r[31:0]) * 64'(z);
      phi_r  <= PHI_W'(a_r[A_W-1:32]) * PHI_W'(z);
      neg3_r <= neg2_r;
    end
  end

  // Combine partials, round half away from zero, shift by 36
  assign prod    = {phi_r, 32'd0} + {{(PROD_W - 64){1'b0}}, plo_r};
  assign rnd     = prod + {{(PROD_W - 64){1'b0}}, 64'h0000_0008_0000_0000};
  assign mag     = rnd[PROD_W-1:36];
  assign mag_big = |mag[MAG_W-1:31];

  // Apply sign and saturate
  always_comb begin
    if (neg3_r) begin
      coord = mag_big ? 32'sh8000_0000 : signed'(32'd0 - mag[31:0]);
    end else begin
      coord = mag_big ? 32'sh7FFF_FFFF : signed'(mag[31:0]);
    end
  end

endmodule

FILE: sv/depth_pixel_backprojection_unit.sv
// Top level of the depth pixel backprojection unit: config registers, pipeline control, output.
//
// Back-projects one depth pixel per clock through a pinhole model. A pixel is taken at every
// edge where start is high; busy is always low, so pixels may arrive back to back. Each result
// appears on out_data with out_strobe high for one cycle, in the order the pixels were taken.
// The stages follow the multiplier chain of the lateral path: offset times inverse focal
// length, then a split product with z, then the round and saturate add into the output
// register. The receiver cannot stall the output. A zero raw depth gives a point with
// point_valid low and every other field zero. Configuration writes take effect at once and
// must only be made while no pixel is in flight.
module depth_pixel_backprojection_unit #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  dpb_pkg::in_item_t                 in_data,
  output logic                              out_strobe,
  output dpb_pkg::out_item_t                out_data,
  input  logic                              cfg_we,
  input  logic [dpb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dpb_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import dpb_pkg::*;

  logic [FACTOR_W-1:0] depth_scale_r;
  logic [CENTER_W-1:0] center_x_r;
  logic [CENTER_W-1:0] center_y_r;
  logic [FACTOR_W-1:0] finv_x_r;
  logic [FACTOR_W-1:0] finv_y_r;

  logic                accept;
  logic [3:1]          vld_r;
  stage_ld_t           ld;

  logic [2:0]          nodata_r;
  logic [COLOR_W-1:0]  red_r   [3];
  logic [COLOR_W-1:0]  green_r [3];
  logic [COLOR_W-1:0]  blue_r  [3];

  logic [POINT_W-1:0]        z_s2;
  logic [POINT_W-1:0]        z_s3;
  logic signed [POINT_W-1:0] x_s3;
  logic signed [POINT_W-1:0] y_s3;

  logic                out_strobe_r;
  out_item_t           out_data_r;
  out_item_t           out_data_nxt;

  // No stall anywhere in the pipeline
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_scale_r <= DEPTH_SCALE_RST;
      center_x_r    <= CENTER_RST;
      center_y_r    <= CENTER_RST;
      finv_x_r      <= FOCAL_INV_RST;
      finv_y_r      <= FOCAL_INV_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEPTH_SCALE: depth_scale_r <= cfg_wdata;
        REG_CENTER_X:    center_x_r    <= cfg_wdata[CENTER_W-1:0];
        REG_CENTER_Y:    center_y_r    <= cfg_wdata[CENTER_W-1:0];
        REG_FOCAL_INV_X: finv_x_r      <= cfg_wdata;
        REG_FOCAL_INV_Y: finv_y_r      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Advance the valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[2:1], accept};
    end
  end

  assign ld.s1 = accept;
  assign ld.s2 = vld_r[1];
  assign ld.s3 = vld_r[2];

  // Carry the no-data flag and color alongside the arithmetic
  always_ff @(posedge clk) begin
    if (ld.s1) begin
      nodata_r[0] <= (in_data.depth_raw == '0);
      red_r[0]    <= in_data.red;
      green_r[0]  <= in_data.green;
      blue_r[0]   <= in_data.blue;
    end
    if (ld.s2) begin
      nodata_r[1] <= nodata_r[0];
      red_r[1]    <= red_r[0];
      green_r[1]  <= green_r[0];
      blue_r[1]   <= blue_r[0];
    end
    if (ld.s3) begin
      nodata_r[2] <= nodata_r[1];
      red_r[2]    <= red_r[1];
      green_r[2]  <= green_r[1];
      blue_r[2]   <= blue_r[1];
    end
  end

  dpb_range u_range (
    .clk         (clk),
    .ld          (ld),
    .depth_raw   (in_data.depth_raw),
    .depth_scale (depth_scale_r),
    .z_s2        (z_s2),
    .z_s3        (z_s3)
  );

  dpb_lateral #(.COORD_BITS(COORD_BITS)) u_lat_x (
    .clk    (clk),
    .ld     (ld),
    .pix    (in_data.column),
    .center (center_x_r),
    .finv   (finv_x_r),
    .z      (z_s2),
    .coord  (x_s3)
  );

  dpb_lateral #(.COORD_BITS(COORD_BITS)) u_lat_y (
    .clk    (clk),
    .ld     (ld),
    .pix    (in_data.row),
    .center (center_y_r),
    .finv   (finv_y_r),
    .z      (z_s2),
    .coord  (y_s3)
  );

  // Assemble the result; drop everything for a no-data pixel
  always_comb begin
    if (nodata_r[2]) begin
      out_data_nxt = '0;
    end else begin
      out_data_nxt.point_valid = 1'b1;
      out_data_nxt.point_x     = x_s3;
      out_data_nxt.point_y     = y_s3;
      out_data_nxt.point_z     = z_s3;
      out_data_nxt.out_red     = red_r[2];
      out_data_nxt.out_green   = green_r[2];
      out_data_nxt.out_blue    = blue_r[2];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= vld_r[3];
    end
  end

  always_ff @(posedge clk) begin
    if (vld_r[3]) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

  // Every accepted beat comes out on out_strobe
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> ##3 out_strobe)
    else $error("accepted beat did not produce a result on time");

  // A nonzero depth yields a valid point
  a_valid_point: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_data.depth_raw != '0) |=> ##3 (out_strobe && out_data.point_valid))
    else $error("nonzero depth gave an invalid point");

  // A zero depth yields an all-zero point
  a_nodata_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_data.depth_raw == '0) |=> ##3
      (out_strobe && out_data.point_x == '0 && out_data.point_y == '0 &&
       out_data.point_z == '0 && out_data.out_red == '0 &&
       out_data.out_green == '0 && out_data.out_blue == '0 && !out_data.point_valid))
    else $error("no-data point carries nonzero fields");

endmodule
